@@ src/dsis_pkg.sv @@
// ----------------------------------------------------------------------------
// dsis_pkg
// Shared types and constants of the downscale sample index search block.
// ----------------------------------------------------------------------------
package dsis_pkg;

    // Default capacity of each index table, in entries.
    localparam int MAX_DIM_DEFAULT = 4096;

    // Configuration port.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Field widths.
    localparam int LEN_W   = 13;
    localparam int RATE_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int COORD_W = 16;
    localparam int START_W = 13;
    localparam int RES_W   = 17;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 24;

    // Inflate rate after reset is 1.0 in Q16.16.
    localparam logic [RATE_W-1:0] RATE_RESET = 32'h0001_0000;
    // One half in Q16.16, added before truncation for round half up.
    localparam logic [RATE_W-1:0] ROUND_HALF = 32'h0000_8000;

    typedef enum logic [1:0] {
        CMD_BUILD,
        CMD_EXACT,
        CMD_LOWER,
        CMD_UPPER
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALING,
        REG_COL_LEN,
        REG_ROW_LEN,
        REG_INFLATE
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_BUILD,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_FINAL_RD,
        ST_FINAL_CMP,
        ST_DONE
    } state_t;

endpackage

@@ src/dsis_ram.sv @@
// ----------------------------------------------------------------------------
// dsis_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module dsis_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/downscale_sample_index_search.sv @@
// ----------------------------------------------------------------------------
// downscale_sample_index_search
// Column and row index tables for nearest neighbor downscaling, filled by a
// build request and searched by lower-bound search for exact, lower and upper queries.
// ----------------------------------------------------------------------------
// A pass-through query goes from dispatch straight to its result. A table
// query runs the read-then-compare loop on the table RAM, and a build steps
// the accumulator through each entry of the longer table.
// One request is in flight at a time. Reset clears the control state, the
// configuration registers and both entry counts; table contents stay undefined.
// ----------------------------------------------------------------------------
module downscale_sample_index_search #(
    parameter int MAX_DIM = dsis_pkg::MAX_DIM_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,

    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [dsis_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dsis_pkg::CFG_DATA_W-1:0]  cfg_data,

    // Request stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata, lowest bit first: coordinate[15:0], search_start[28:16], zero pad.
    input  logic [dsis_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser, lowest bit first: command[1:0], axis[2].
    input  logic [dsis_pkg::IN_TUSER_W-1:0]  s_axis_tuser,

    // Result stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata, lowest bit first: result_index[16:0] (signed), zero pad.
    output logic [dsis_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // Table addresses and stored values both span the entry range, and a count
    // must be able to hold MAX_DIM itself.
    localparam int AW    = $clog2(MAX_DIM);
    localparam int VAL_W = AW;
    localparam int CNT_W = $clog2(MAX_DIM + 1);
    // The build accumulator holds n * rate + 0.5 for n up to MAX_DIM.
    localparam int ACC_W = dsis_pkg::RATE_W + CNT_W + 1;
    localparam int V_W   = ACC_W - dsis_pkg::FRAC_W;
    localparam int RES_W = dsis_pkg::RES_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                           scaling_reg;
    logic [dsis_pkg::LEN_W-1:0]     col_len_reg;
    logic [dsis_pkg::LEN_W-1:0]     row_len_reg;
    logic [dsis_pkg::RATE_W-1:0]    rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scaling_reg <= 1'b0;
            col_len_reg <= '0;
            row_len_reg <= '0;
            rate_reg    <= dsis_pkg::RATE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (dsis_pkg::cfg_reg_t'(cfg_index))
                dsis_pkg::REG_SCALING: scaling_reg <= cfg_data[0];
                dsis_pkg::REG_COL_LEN: col_len_reg <= cfg_data[dsis_pkg::LEN_W-1:0];
                dsis_pkg::REG_ROW_LEN: row_len_reg <= cfg_data[dsis_pkg::LEN_W-1:0];
                dsis_pkg::REG_INFLATE: rate_reg    <= cfg_data[dsis_pkg::RATE_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state and datapath registers
    // ------------------------------------------------------------------
    dsis_pkg::state_t state_reg, state_next;

    // Captured request (payload, no reset needed).
    dsis_pkg::cmd_t                 cmd_reg, cmd_next;
    logic                           axis_reg, axis_next;
    logic [dsis_pkg::COORD_W-1:0]   coord_reg, coord_next;
    logic [dsis_pkg::START_W-1:0]   start_reg, start_next;

    // Entry counts of the two tables.
    logic [CNT_W-1:0]               col_count_reg, col_count_next;
    logic [CNT_W-1:0]               row_count_reg, row_count_next;

    // Build: entry number and the running product n * rate + 0.5.
    logic [CNT_W-1:0]               n_reg, n_next;
    logic [ACC_W-1:0]               acc_reg, acc_next;

    // Search window [lo, hi).
    logic [CNT_W-1:0]               lo_reg, lo_next;
    logic [CNT_W-1:0]               hi_reg, hi_next;

    // Finished result and the output register that presents it.
    logic [RES_W-1:0]               res_reg, res_next;
    logic [RES_W-1:0]               out_data_reg, out_data_next;
    logic                           out_valid_reg, out_valid_next;

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic                           accept;
    logic [V_W-1:0]                 build_value;
    logic [CNT_W-1:0]               col_lim;
    logic [CNT_W-1:0]               row_lim;
    logic                           n_in_range;
    logic                           col_fit;
    logic                           row_fit;
    logic [CNT_W-1:0]               sel_count;
    logic [CNT_W-1:0]               start_clamped;
    logic [CNT_W-1:0]               mid;
    logic [AW-1:0]                  rd_addr;
    logic [VAL_W-1:0]               col_rdata;
    logic [VAL_W-1:0]               row_rdata;
    logic [VAL_W-1:0]               rdata;
    logic                           entry_below;
    logic                           entry_equal;
    logic [RES_W-1:0]               idx_res;
    logic [RES_W-1:0]               idx_minus_one;

    assign accept = s_axis_tvalid && s_axis_tready;

    // Rounded table value of the current entry, round half up of n * rate.
    assign build_value = acc_reg[ACC_W-1:dsis_pkg::FRAC_W];

    // An axis longer than the table capacity is treated as MAX_DIM long.
    assign col_lim = (32'(col_len_reg) > 32'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(col_len_reg);
    assign row_lim = (32'(row_len_reg) > 32'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(row_len_reg);

    // The table values never decrease with n, so once an entry fails to fit
    // every later one fails too, and each count stops at its first miss.
    assign n_in_range = 32'(n_reg) < 32'(MAX_DIM);
    assign col_fit    = n_in_range && (build_value < V_W'(col_lim));
    assign row_fit    = n_in_range && (build_value < V_W'(row_lim));

    assign sel_count     = axis_reg ? row_count_reg : col_count_reg;
    assign start_clamped = (32'(start_reg) > 32'(sel_count)) ? sel_count
                                                             : CNT_W'(start_reg);

    // Midpoint of the window; the shared compare below decides which half.
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // The search reads at the midpoint, the final check reads at lo.
    assign rd_addr = (state_reg == dsis_pkg::ST_SEARCH_RD) ? mid[AW-1:0] : lo_reg[AW-1:0];

    assign rdata       = axis_reg ? row_rdata : col_rdata;
    assign entry_below = 32'(rdata) < 32'(coord_reg);
    assign entry_equal = 32'(rdata) == 32'(coord_reg);

    assign idx_res       = RES_W'(lo_reg);
    assign idx_minus_one = idx_res - RES_W'(1);

    // Both tables are written in the same build pass with the same value.
    dsis_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_DIM)
    ) u_col_ram (
        .clk   (clk),
        .we    ((state_reg == dsis_pkg::ST_BUILD) && col_fit),
        .waddr (n_reg[AW-1:0]),
        .wdata (build_value[VAL_W-1:0]),
        .raddr (rd_addr),
        .rdata (col_rdata)
    );

    dsis_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_DIM)
    ) u_row_ram (
        .clk   (clk),
        .we    ((state_reg == dsis_pkg::ST_BUILD) && row_fit),
        .waddr (n_reg[AW-1:0]),
        .wdata (build_value[VAL_W-1:0]),
        .raddr (rd_addr),
        .rdata (row_rdata)
    );

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dsis_pkg::ST_IDLE;
            col_count_reg <= '0;
            row_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        axis_reg     <= axis_next;
        coord_reg    <= coord_next;
        start_reg    <= start_next;
        n_reg        <= n_next;
        acc_reg      <= acc_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        axis_next      = axis_reg;
        coord_next     = coord_reg;
        start_next     = start_reg;
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        n_next         = n_reg;
        acc_next       = acc_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        // The waiting result leaves when the consumer takes it.
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            dsis_pkg::ST_IDLE:
            begin
                // New requests are taken here even while a result still waits.
                if (accept)
                begin
                    cmd_next   = dsis_pkg::cmd_t'(s_axis_tuser[1:0]);
                    axis_next  = s_axis_tuser[2];
                    coord_next = s_axis_tdata[dsis_pkg::COORD_W-1:0];
                    start_next = s_axis_tdata[dsis_pkg::COORD_W +: dsis_pkg::START_W];
                    state_next = dsis_pkg::ST_DISPATCH;
                end
            end

            dsis_pkg::ST_DISPATCH:
            begin
                priority if (cmd_reg == dsis_pkg::CMD_BUILD)
                begin
                    n_next         = '0;
                    acc_next       = ACC_W'(dsis_pkg::ROUND_HALF);
                    col_count_next = '0;
                    row_count_next = '0;
                    state_next     = dsis_pkg::ST_BUILD;
                end
                else if (!scaling_reg || (sel_count == '0))
                begin
                    // Unscaled or empty table: the coordinate passes through.
                    res_next   = RES_W'(coord_reg);
                    state_next = dsis_pkg::ST_DONE;
                end
                else
                begin
                    lo_next    = start_clamped;
                    hi_next    = sel_count;
                    state_next = dsis_pkg::ST_SEARCH_RD;
                end
            end

            dsis_pkg::ST_BUILD:
            begin
                if (col_fit || row_fit)
                begin
                    if (col_fit)
                    begin
                        col_count_next = col_count_reg + CNT_W'(1);
                    end
                    if (row_fit)
                    begin
                        row_count_next = row_count_reg + CNT_W'(1);
                    end
                    n_next   = n_reg + CNT_W'(1);
                    acc_next = acc_reg + ACC_W'(rate_reg);
                end
                else
                begin
                    res_next   = RES_W'(col_count_reg);
                    state_next = dsis_pkg::ST_DONE;
                end
            end

            dsis_pkg::ST_SEARCH_RD:
            begin
                // The entry at mid is read during this cycle when the window is open.
                if (lo_reg < hi_reg)
                begin
                    state_next = dsis_pkg::ST_SEARCH_CMP;
                end
                else
                begin
                    state_next = dsis_pkg::ST_FINAL_RD;
                end
            end

            dsis_pkg::ST_SEARCH_CMP:
            begin
                if (entry_below)
                begin
                    lo_next = mid + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = dsis_pkg::ST_SEARCH_RD;
            end

            dsis_pkg::ST_FINAL_RD:
            begin
                if (lo_reg < sel_count)
                begin
                    state_next = dsis_pkg::ST_FINAL_CMP;
                end
                else
                begin
                    // Nothing at or above the coordinate.
                    res_next   = (cmd_reg == dsis_pkg::CMD_LOWER) ? idx_minus_one : '1;
                    state_next = dsis_pkg::ST_DONE;
                end
            end

            dsis_pkg::ST_FINAL_CMP:
            begin
                priority if (entry_equal)
                begin
                    res_next = idx_res;
                end
                else if (cmd_reg == dsis_pkg::CMD_LOWER)
                begin
                    res_next = idx_minus_one;
                end
                else if (cmd_reg == dsis_pkg::CMD_UPPER)
                begin
                    res_next = idx_res;
                end
                else
                begin
                    res_next = '1;
                end
                state_next = dsis_pkg::ST_DONE;
            end

            dsis_pkg::ST_DONE:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = dsis_pkg::ST_IDLE;
                end
            end
        endcase
    end

    assign s_axis_tready = (state_reg == dsis_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = dsis_pkg::OUT_TDATA_W'(out_data_reg);

endmodule

@@ src/dsis_checker.sv @@
// ----------------------------------------------------------------------------
// dsis_checker
// Port-level checks of the downscale sample index search block.
// ----------------------------------------------------------------------------
module dsis_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [dsis_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // Only one request is worked on at a time.
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in progress");

    // No result can be ready in the cycle right after a request.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early after a request");

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_data_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind downscale_sample_index_search dsis_checker u_dsis_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
